/* hw/rtl/hcb_pkg.sv */
// Shared types and codes for the code table builder.
// Command/status structs join hcb_ctrl and hcb_dp; no dependencies.
package hcb_pkg;

  typedef enum logic [1:0] {
    FUNC_COUNT  = 2'd0,
    FUNC_BUILD  = 2'd1,
    FUNC_LOOKUP = 2'd2
  } func_e;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_SAT     = 2'd1;
  localparam logic [1:0] ERR_LONG    = 2'd2;
  localparam logic [1:0] ERR_UNBUILT = 2'd3;

  localparam logic KIND_BUILD  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam int LEN_W      = 6;
  localparam int CODE_W     = 32;
  localparam int FREQ_W     = 20;
  localparam int USED_W     = 9;
  localparam int OUT_DATA_W = 72;

  typedef struct packed {
    logic take;
    logic cnt_rd;
    logic cnt_wr;
    logic lk_rd;
    logic lk_out;
    logic build_clr;
    logic scan_clr;
    logic scan_step;
    logic pass_end;
    logic m_init;
    logic m_fill;
    logic m_cap;
    logic m_pick;
    logic m_write;
    logic w_init;
    logic w_rd;
    logic w_cap;
    logic w_left;
    logic w_right;
    logic rpt_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic few;
    logic pick_b;
    logic last_merge;
    logic p_zero;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/hcb_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module hcb_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/hcb_ctrl.sv */
// Sequencer for count, lookup and the sort / merge / tree-walk build.
// Depends on hcb_pkg; drives hcb_dp through cmd_t, reads sts_t.
module hcb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  input  logic [1:0]    func_i,
  input  hcb_pkg::sts_t sts_i,
  output hcb_pkg::cmd_t cmd_o,
  output logic          s_tready_o
);
  import hcb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CNT_RD, ST_CNT_WR, ST_LK_RD, ST_LK_OUT,
    ST_B_INIT, ST_S_SCAN, ST_S_PASS,
    ST_M_INIT, ST_M_FILL, ST_M_CAP, ST_M_PICK, ST_M_WRITE,
    ST_W_INIT, ST_W_RD, ST_W_CAP, ST_W_LEFT, ST_W_RIGHT,
    ST_RPT
  } state_e;

  state_e state_q, state_d;
  func_e  func;

  assign func       = func_e'(func_i);
  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.take = s_tvalid_i;
        if (s_tvalid_i) begin
          case (func)
            FUNC_COUNT:  state_d = ST_CNT_RD;
            FUNC_BUILD:  state_d = ST_B_INIT;
            FUNC_LOOKUP: state_d = ST_LK_RD;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_CNT_RD: begin
        cmd_o.cnt_rd = 1'b1;
        state_d      = ST_CNT_WR;
      end
      ST_CNT_WR: begin
        cmd_o.cnt_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_LK_RD: begin
        cmd_o.lk_rd = 1'b1;
        state_d     = ST_LK_OUT;
      end
      ST_LK_OUT: begin
        cmd_o.lk_out = sts_i.out_free;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_B_INIT: begin
        cmd_o.build_clr = 1'b1;
        cmd_o.scan_clr  = 1'b1;
        state_d         = ST_S_SCAN;
      end
      ST_S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = ST_S_PASS;
      end
      ST_S_PASS: begin
        cmd_o.pass_end = 1'b1;
        cmd_o.scan_clr = 1'b1;
        state_d        = sts_i.found ? ST_S_SCAN : ST_M_INIT;
      end
      ST_M_INIT: begin
        cmd_o.m_init = 1'b1;
        state_d      = sts_i.few ? ST_RPT : ST_M_FILL;
      end
      ST_M_FILL: begin
        cmd_o.m_fill = 1'b1;
        state_d      = ST_M_CAP;
      end
      ST_M_CAP: begin
        cmd_o.m_cap = 1'b1;
        state_d     = ST_M_PICK;
      end
      ST_M_PICK: begin
        cmd_o.m_pick = 1'b1;
        state_d      = sts_i.pick_b ? ST_M_WRITE : ST_M_FILL;
      end
      ST_M_WRITE: begin
        cmd_o.m_write = 1'b1;
        state_d       = sts_i.last_merge ? ST_W_INIT : ST_M_FILL;
      end
      ST_W_INIT: begin
        cmd_o.w_init = 1'b1;
        state_d      = ST_W_RD;
      end
      ST_W_RD: begin
        cmd_o.w_rd = 1'b1;
        state_d    = ST_W_CAP;
      end
      ST_W_CAP: begin
        cmd_o.w_cap = 1'b1;
        state_d     = ST_W_LEFT;
      end
      ST_W_LEFT: begin
        cmd_o.w_left = 1'b1;
        state_d      = ST_W_RIGHT;
      end
      ST_W_RIGHT: begin
        cmd_o.w_right = 1'b1;
        state_d       = sts_i.p_zero ? ST_RPT : ST_W_RD;
      end
      ST_RPT: begin
        cmd_o.rpt_out = sts_i.out_free;
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* hw/rtl/hcb_dp.sv */
// Datapath: histogram, sorted leaf list, node, depth/code and table memories,
// scan comparator, two-queue merge, tree walk and output register.
// Depends on hcb_pkg and hcb_ram; driven by hcb_ctrl.
module hcb_dp #(
  parameter int SYMBOLS       = 256,
  parameter int COUNT_BITS    = 20,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hcb_pkg::cmd_t                       cmd_i,
  output hcb_pkg::sts_t                       sts_o,
  input  logic [7:0]                          s_data_i,
  input  logic                                m_tready_i,
  output logic                                m_tvalid_o,
  output logic [hcb_pkg::OUT_DATA_W-1:0]      m_tdata_o,
  output logic                                m_tuser_o
);
  import hcb_pkg::*;

  localparam int IDX_W  = $clog2(SYMBOLS);
  localparam int CNT_W  = $clog2(SYMBOLS + 1);
  localparam int REF_W  = IDX_W + 1;
  localparam int WGT_W  = COUNT_BITS + IDX_W;
  localparam int SKEY_W = COUNT_BITS + IDX_W;
  localparam int NODE_W = WGT_W + 2 * REF_W;
  localparam int DC_W   = IDX_W + CODE_W;
  localparam int TBL_W  = LEN_W + CODE_W;
  localparam int INT_N  = SYMBOLS - 1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // input beat
  logic [IDX_W-1:0] sym_q;
  logic             sym_ok_q;

  // histogram
  logic [SYMBOLS-1:0]    hist_vld_q;
  logic                  hist_rvld_q;
  logic [COUNT_BITS-1:0] hist_rdata, hist_val, hist_inc;
  logic [IDX_W-1:0]      hist_raddr;
  logic                  hist_re, hist_we;
  logic                  sat_q;

  // selection scan
  logic [CNT_W-1:0]  j_q, n_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic              found_q, have_prev_q;
  logic [SKEY_W-1:0] best_q, prev_q, key;
  logic              cand, eval;

  // merge
  logic [SKEY_W-1:0] sort_rdata;
  logic              sort_re, sort_we;
  logic [CNT_W-1:0]  lrd_q, merges_q;
  logic [IDX_W-1:0]  ird_q, iwr_q;
  logic              lh_v_q, ih_v_q, lpend_q, ipend_q, pick_b_q;
  logic [WGT_W-1:0]  lh_w_q, ih_w_q, a_w_q, b_w_q, pick_w;
  logic [REF_W-1:0]  lh_r_q, ih_r_q, a_r_q, b_r_q, pick_r;
  logic              take_leaf, node_m_re;
  logic [NODE_W-1:0] node_rdata;
  logic [IDX_W-1:0]  node_raddr;

  // tree walk
  logic [IDX_W-1:0]  p_q, pd_q, cdep;
  logic              root_q, too_long_q;
  logic [REF_W-1:0]  chl_q, chr_q, ch;
  logic [CODE_W-1:0] pc_q, ccode;
  logic [DC_W-1:0]   dc_rdata;
  logic              dc_we, tbl_we, child_wr;

  // table and output
  logic [SYMBOLS-1:0] tbl_vld_q;
  logic               tbl_rvld_q, tbl_re, built_q;
  logic [TBL_W-1:0]   tbl_rdata;
  logic               out_valid_q, out_kind_q;
  logic [USED_W-1:0]  out_used_q;
  logic [LEN_W-1:0]   out_len_q;
  logic [CODE_W-1:0]  out_code_q;
  logic [FREQ_W-1:0]  out_freq_q;
  logic [1:0]         out_err_q;

  // ---------------- combinational ----------------
  assign hist_raddr = cmd_i.scan_step ? j_q[IDX_W-1:0] : sym_q;
  assign hist_re    = ((cmd_i.cnt_rd | cmd_i.lk_rd) & sym_ok_q) |
                      (cmd_i.scan_step & (j_q != CNT_W'(SYMBOLS)));
  assign hist_val   = hist_rvld_q ? hist_rdata : '0;
  assign hist_inc   = (hist_val == CNT_MAX) ? hist_val : hist_val + 1'b1;
  assign hist_we    = cmd_i.cnt_wr & sym_ok_q;

  assign key  = {hist_val, rd_idx_q};
  assign eval = cmd_i.scan_step & (j_q != '0);
  assign cand = (hist_val != '0) && (!have_prev_q || key > prev_q) &&
                (!found_q || key < best_q);

  assign sort_we   = cmd_i.pass_end & found_q;
  assign sort_re   = cmd_i.m_fill & !lh_v_q & (lrd_q < n_q);
  assign node_m_re = cmd_i.m_fill & !ih_v_q & (ird_q < iwr_q);
  assign node_raddr = cmd_i.w_rd ? p_q : ird_q;

  // leaves win ties against merged nodes
  assign take_leaf = lh_v_q && (!ih_v_q || lh_w_q <= ih_w_q);
  assign pick_w    = take_leaf ? lh_w_q : ih_w_q;
  assign pick_r    = take_leaf ? lh_r_q : ih_r_q;

  assign child_wr = cmd_i.w_left | cmd_i.w_right;
  assign ch       = cmd_i.w_left ? chl_q : chr_q;
  assign cdep     = pd_q + 1'b1;
  assign ccode    = {pc_q[CODE_W-2:0], cmd_i.w_right};
  assign dc_we    = child_wr & ch[IDX_W];
  assign tbl_we   = child_wr & !ch[IDX_W];
  assign tbl_re   = cmd_i.lk_rd & sym_ok_q;

  assign sts_o.scan_done  = (j_q == CNT_W'(SYMBOLS));
  assign sts_o.found      = found_q;
  assign sts_o.few        = (n_q <= CNT_W'(1));
  assign sts_o.pick_b     = pick_b_q;
  assign sts_o.last_merge = (merges_q == CNT_W'(1));
  assign sts_o.p_zero     = (p_q == '0);
  assign sts_o.out_free   = !out_valid_q || m_tready_i;

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tdata_o  = {3'b000, out_err_q, out_freq_q, out_code_q, out_len_q, out_used_q};

  // ---------------- memories ----------------
  hcb_ram #(.WIDTH(COUNT_BITS), .DEPTH(SYMBOLS), .ADDR_W(IDX_W)) u_hist_ram (
    .clk_i, .we_i(hist_we), .waddr_i(sym_q), .wdata_i(hist_inc),
    .re_i(hist_re), .raddr_i(hist_raddr), .rdata_o(hist_rdata)
  );

  hcb_ram #(.WIDTH(SKEY_W), .DEPTH(SYMBOLS), .ADDR_W(IDX_W)) u_sort_ram (
    .clk_i, .we_i(sort_we), .waddr_i(n_q[IDX_W-1:0]), .wdata_i(best_q),
    .re_i(sort_re), .raddr_i(lrd_q[IDX_W-1:0]), .rdata_o(sort_rdata)
  );

  hcb_ram #(.WIDTH(NODE_W), .DEPTH(INT_N), .ADDR_W(IDX_W)) u_node_ram (
    .clk_i, .we_i(cmd_i.m_write), .waddr_i(iwr_q),
    .wdata_i({a_w_q + b_w_q, b_r_q, a_r_q}),
    .re_i(node_m_re | cmd_i.w_rd), .raddr_i(node_raddr), .rdata_o(node_rdata)
  );

  hcb_ram #(.WIDTH(DC_W), .DEPTH(INT_N), .ADDR_W(IDX_W)) u_dc_ram (
    .clk_i, .we_i(dc_we), .waddr_i(ch[IDX_W-1:0]), .wdata_i({cdep, ccode}),
    .re_i(cmd_i.w_rd), .raddr_i(p_q), .rdata_o(dc_rdata)
  );

  hcb_ram #(.WIDTH(TBL_W), .DEPTH(SYMBOLS), .ADDR_W(IDX_W)) u_tbl_ram (
    .clk_i, .we_i(tbl_we), .waddr_i(ch[IDX_W-1:0]), .wdata_i({LEN_W'(cdep), ccode}),
    .re_i(tbl_re), .raddr_i(sym_q), .rdata_o(tbl_rdata)
  );

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q  <= '0;
      hist_rvld_q <= 1'b0;
      tbl_vld_q   <= '0;
      tbl_rvld_q  <= 1'b0;
      sat_q       <= 1'b0;
      built_q     <= 1'b0;
      too_long_q  <= 1'b0;
      out_valid_q <= 1'b0;
      j_q         <= '0;
      n_q         <= '0;
      found_q     <= 1'b0;
      have_prev_q <= 1'b0;
      lrd_q       <= '0;
      ird_q       <= '0;
      iwr_q       <= '0;
      merges_q    <= '0;
      lh_v_q      <= 1'b0;
      ih_v_q      <= 1'b0;
      lpend_q     <= 1'b0;
      ipend_q     <= 1'b0;
      pick_b_q    <= 1'b0;
      p_q         <= '0;
      root_q      <= 1'b0;
    end else begin
      if (hist_re) hist_rvld_q <= hist_vld_q[hist_raddr];
      if (hist_we) begin
        hist_vld_q[sym_q] <= 1'b1;
        if (hist_inc == CNT_MAX) sat_q <= 1'b1;
      end
      if (tbl_re) tbl_rvld_q <= tbl_vld_q[sym_q];
      if (tbl_we) begin
        tbl_vld_q[ch[IDX_W-1:0]] <= 1'b1;
        if (int'(cdep) > MAX_CODE_BITS) too_long_q <= 1'b1;
      end

      // selection scan
      if (cmd_i.build_clr) begin
        n_q         <= '0;
        have_prev_q <= 1'b0;
        too_long_q  <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        if (j_q != CNT_W'(SYMBOLS)) j_q <= j_q + 1'b1;
        if (eval && cand) found_q <= 1'b1;
      end
      if (sort_we) begin
        n_q         <= n_q + 1'b1;
        have_prev_q <= 1'b1;
      end
      if (cmd_i.scan_clr) begin
        j_q     <= '0;
        found_q <= 1'b0;
      end

      // merge
      if (cmd_i.m_init) begin
        lrd_q    <= '0;
        ird_q    <= '0;
        iwr_q    <= '0;
        lh_v_q   <= 1'b0;
        ih_v_q   <= 1'b0;
        pick_b_q <= 1'b0;
        merges_q <= n_q - 1'b1;
      end
      if (cmd_i.m_fill) begin
        lpend_q <= sort_re;
        ipend_q <= node_m_re;
      end
      if (cmd_i.m_cap) begin
        if (lpend_q) begin
          lh_v_q <= 1'b1;
          lrd_q  <= lrd_q + 1'b1;
        end
        if (ipend_q) begin
          ih_v_q <= 1'b1;
          ird_q  <= ird_q + 1'b1;
        end
      end
      if (cmd_i.m_pick) begin
        pick_b_q <= !pick_b_q;
        if (take_leaf) lh_v_q <= 1'b0;
        else           ih_v_q <= 1'b0;
      end
      if (cmd_i.m_write) begin
        iwr_q    <= iwr_q + 1'b1;
        merges_q <= merges_q - 1'b1;
      end

      // walk from the root down; parents sit above their children
      if (cmd_i.w_init) begin
        p_q    <= iwr_q - 1'b1;
        root_q <= 1'b1;
      end
      if (cmd_i.w_cap) root_q <= 1'b0;
      if (cmd_i.w_right && (p_q != '0)) p_q <= p_q - 1'b1;

      // output register
      if (cmd_i.lk_out || cmd_i.rpt_out) out_valid_q <= 1'b1;
      else if (m_tready_i)               out_valid_q <= 1'b0;
      if (cmd_i.rpt_out) built_q <= !too_long_q;
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      sym_q    <= s_data_i[IDX_W-1:0];
      sym_ok_q <= (9'(s_data_i) < 9'(SYMBOLS));
    end
    if (cmd_i.scan_step && (j_q != CNT_W'(SYMBOLS))) rd_idx_q <= j_q[IDX_W-1:0];
    if (eval && cand) best_q <= key;
    if (sort_we) prev_q <= best_q;
    if (cmd_i.m_cap) begin
      if (lpend_q) begin
        lh_w_q <= WGT_W'(sort_rdata[SKEY_W-1:IDX_W]);
        lh_r_q <= {1'b0, sort_rdata[IDX_W-1:0]};
      end
      if (ipend_q) begin
        ih_w_q <= node_rdata[NODE_W-1:2*REF_W];
        ih_r_q <= {1'b1, ird_q};
      end
    end
    if (cmd_i.m_pick) begin
      if (pick_b_q) begin
        b_w_q <= pick_w;
        b_r_q <= pick_r;
      end else begin
        a_w_q <= pick_w;
        a_r_q <= pick_r;
      end
    end
    if (cmd_i.w_cap) begin
      chl_q <= node_rdata[REF_W-1:0];
      chr_q <= node_rdata[2*REF_W-1:REF_W];
      pd_q  <= root_q ? '0 : dc_rdata[DC_W-1:CODE_W];
      pc_q  <= root_q ? '0 : dc_rdata[CODE_W-1:0];
    end
    if (cmd_i.lk_out) begin
      out_kind_q <= KIND_LOOKUP;
      out_used_q <= '0;
      out_freq_q <= sym_ok_q ? FREQ_W'(hist_val) : '0;
      if (sym_ok_q && built_q && tbl_rvld_q) begin
        out_len_q  <= tbl_rdata[TBL_W-1:CODE_W];
        out_code_q <= tbl_rdata[CODE_W-1:0];
      end else begin
        out_len_q  <= '0;
        out_code_q <= '0;
      end
      if (!built_q)                           out_err_q <= ERR_UNBUILT;
      else if (sym_ok_q && hist_val == CNT_MAX) out_err_q <= ERR_SAT;
      else                                    out_err_q <= ERR_OK;
    end
    if (cmd_i.rpt_out) begin
      out_kind_q <= KIND_BUILD;
      out_used_q <= USED_W'(n_q);
      out_len_q  <= '0;
      out_code_q <= '0;
      out_freq_q <= '0;
      if (too_long_q)  out_err_q <= ERR_LONG;
      else if (sat_q)  out_err_q <= ERR_SAT;
      else             out_err_q <= ERR_OK;
    end
  end

`ifndef SYNTHESIS
  a_pick_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.m_pick |-> (lh_v_q || ih_v_q))
    else $error("merge pick with both queue heads empty");
  a_node_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.m_write |-> (int'(iwr_q) < INT_N))
    else $error("merged node beyond node memory");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.lk_out || cmd_i.rpt_out) |-> (!out_valid_q || m_tready_i))
    else $error("result loaded over a pending beat");
  a_sort_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sort_we |-> (n_q < CNT_W'(SYMBOLS)))
    else $error("sorted list overflow");
`endif

endmodule

/* hw/rtl/huffman_code_table_builder_top.sv */
// Top level of the byte-alphabet prefix code table builder.
// Depends on hcb_pkg, hcb_ctrl, hcb_dp (which holds the hcb_ram instances).
//
// Input stream: tuser = func (0 count, 1 build, 2 lookup, 3 dropped),
// tdata = data byte. Output stream: tuser = kind (0 build report, 1 lookup).
// A count beat runs a histogram read-modify-write and gives no result. A
// lookup reads the histogram and table, then loads its result beat. A build
// runs a selection sort, one scan of the histogram per used symbol plus one,
// then the merges of the lightest two heads, then the walk over the internal
// nodes; the sort scan over the histogram RAM dominates.
// One command is worked on at a time; tready is high only between commands.
// A result sits in an output register, so the next command is taken while
// it waits; a command with a result holds until that register is free when
// the receiver stalls.
// Reset clears histogram and table valid bits directly: no clearing pass.
module huffman_code_table_builder_top #(
  parameter int SYMBOLS       = 256,
  parameter int COUNT_BITS    = 20,
  parameter int MAX_CODE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [8:0] used_symbols, [14:9] code_length, [46:15] code_bits,
  // [66:47] symbol_frequency, [68:67] error_code, [71:69] zero
  output logic [71:0] m_axis_tdata_o,
  output logic [0:0]  m_axis_tuser_o    // [0] answer_kind
);

  hcb_pkg::cmd_t cmd;
  hcb_pkg::sts_t sts;

  hcb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_tvalid_i (s_axis_tvalid_i),
    .func_i     (s_axis_tuser_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .s_tready_o (s_axis_tready_o)
  );

  hcb_dp #(
    .SYMBOLS       (SYMBOLS),
    .COUNT_BITS    (COUNT_BITS),
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_data_i   (s_axis_tdata_i),
    .m_tready_i (m_axis_tready_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o),
    .m_tuser_o  (m_axis_tuser_o[0])
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for huffman_code_table_builder_top.
// Counts bytes, builds and looks up codes, and checks every result beat
// against an in-bench histogram and code tree. Needs hcb_pkg and the RTL.
`timescale 1ns / 100ps

module tb_top;
  import hcb_pkg::*;

  localparam int NSYM = 256;
  localparam int COUNT_LIMIT = (1 << 20) - 1;
  localparam int MAX_BITS = 32;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct {
    logic        kind;
    logic [8:0]  used;
    logic [5:0]  len;
    logic [31:0] code;
    logic [19:0] freq;
    logic [1:0]  err;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [0:0]  m_tuser;

  answer_t answers_due[$];
  int      hist_cnt[NSYM];
  int      len_tab[NSYM];
  longint unsigned code_tab[NSYM];
  bit      table_ok;
  bit      any_sat;
  int      errors = 0;
  bit      quiet = 1'b0;
  bit      hold_req = 1'b0;
  int      hold_cycles = 0;

  huffman_code_table_builder_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Sort used symbols, merge the two lightest, walk the tree from the root.
  function automatic logic [1:0] build_codes(output int used);
    int lst[NSYM + 1];
    int wt[2 * NSYM - 1];
    int kid_l[2 * NSYM - 1];
    int kid_r[2 * NSYM - 1];
    int dep[2 * NSYM - 1];
    longint unsigned cd[2 * NSYM - 1];
    int n, nxt, k, j, a, b, pos, w, p;
    bit too_long;
    n = 0;
    nxt = NSYM;
    too_long = 0;
    for (int i = 0; i < NSYM; i++) begin
      if (hist_cnt[i] == 0) continue;
      wt[i] = hist_cnt[i];
      k = n;
      while (k > 0 && wt[lst[k - 1]] > hist_cnt[i]) begin
        lst[k] = lst[k - 1];
        k--;
      end
      lst[k] = i;
      n++;
    end
    used = n;
    while (n > 1) begin
      a = lst[0];
      b = lst[1];
      w = wt[a] + wt[b];
      wt[nxt] = w;
      kid_l[nxt] = a;
      kid_r[nxt] = b;
      for (j = 0; j < n - 2; j++) lst[j] = lst[j + 2];
      n -= 2;
      pos = 0;
      while (pos < n && wt[lst[pos]] <= w) pos++;
      for (j = n; j > pos; j--) lst[j] = lst[j - 1];
      lst[pos] = nxt;
      n++;
      nxt++;
    end
    for (j = 0; j < 2 * NSYM - 1; j++) begin
      dep[j] = 0;
      cd[j] = 0;
    end
    for (k = nxt; k > NSYM; k--) begin
      p = k - 1;
      dep[kid_l[p]] = dep[p] + 1;
      cd[kid_l[p]] = cd[p] << 1;
      dep[kid_r[p]] = dep[p] + 1;
      cd[kid_r[p]] = (cd[p] << 1) | 64'd1;
    end
    for (int i = 0; i < NSYM; i++)
      if (hist_cnt[i] != 0 && dep[i] > MAX_BITS) too_long = 1;
    for (int i = 0; i < NSYM; i++) begin
      len_tab[i] = (hist_cnt[i] != 0 && !too_long) ? dep[i] : 0;
      code_tab[i] = (hist_cnt[i] != 0 && !too_long) ? cd[i] : 0;
    end
    table_ok = !too_long;
    if (too_long) return ERR_LONG;
    return any_sat ? ERR_SAT : ERR_OK;
  endfunction

  // Apply one accepted beat to the bench state; queue any answer it causes.
  task automatic apply_beat(input logic [1:0] f, input logic [7:0] sym);
    answer_t ans;
    int used;
    ans = '{kind: KIND_BUILD, used: '0, len: '0, code: '0, freq: '0, err: ERR_OK};
    case (f)
      FUNC_COUNT: begin
        if (hist_cnt[sym] < COUNT_LIMIT) hist_cnt[sym]++;
        if (hist_cnt[sym] >= COUNT_LIMIT) any_sat = 1;
      end
      FUNC_BUILD: begin
        ans.err = build_codes(used);
        ans.used = used[8:0];
        answers_due.push_back(ans);
      end
      FUNC_LOOKUP: begin
        ans.kind = KIND_LOOKUP;
        ans.freq = hist_cnt[sym][19:0];
        if (table_ok) begin
          ans.len = len_tab[sym][5:0];
          ans.code = code_tab[sym][31:0];
          ans.err = (hist_cnt[sym] >= COUNT_LIMIT) ? ERR_SAT : ERR_OK;
        end else begin
          ans.err = ERR_UNBUILT;
        end
        answers_due.push_back(ans);
      end
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [1:0] f, input logic [7:0] sym);
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= sym;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    apply_beat(f, sym);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_req) hold_cycles <= hold_cycles + 1;
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (hold_req && hold_cycles < 400) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected beat", m_tdata[63:0], 64'd0);
      end else begin
        want = answers_due.pop_front();
        if (m_tuser[0] !== want.kind)
          report_mismatch("answer_kind", 64'(m_tuser), 64'(want.kind));
        if (m_tdata[8:0] !== want.used)
          report_mismatch("used_symbols", 64'(m_tdata[8:0]), 64'(want.used));
        if (m_tdata[14:9] !== want.len)
          report_mismatch("code_length", 64'(m_tdata[14:9]), 64'(want.len));
        if (m_tdata[46:15] !== want.code)
          report_mismatch("code_bits", 64'(m_tdata[46:15]), 64'(want.code));
        if (m_tdata[66:47] !== want.freq)
          report_mismatch("symbol_frequency", 64'(m_tdata[66:47]), 64'(want.freq));
        if (m_tdata[68:67] !== want.err)
          report_mismatch("error_code", 64'(m_tdata[68:67]), 64'(want.err));
      end
    end
  end

  task automatic test_empty_table;
    send_beat(FUNC_LOOKUP, 8'h00);
    send_beat(FUNC_BUILD, 8'hff);
    send_beat(FUNC_LOOKUP, 8'hff);
    send_beat(FUNC_UNUSED, 8'h00);
    send_beat(FUNC_UNUSED, 8'hff);
  endtask

  task automatic test_lone_symbol;
    repeat (3) send_beat(FUNC_COUNT, 8'hff);
    send_beat(FUNC_BUILD, 8'h00);
    send_beat(FUNC_LOOKUP, 8'hff);
    send_beat(FUNC_LOOKUP, 8'h00);
  endtask

  // Fibonacci-like counts give a deep, skewed tree; ties exercise ordering.
  task automatic test_skewed_tree;
    int wts[8] = '{1, 1, 2, 3, 5, 8, 13, 21};
    for (int s = 0; s < 8; s++)
      repeat (wts[s]) send_beat(FUNC_COUNT, 8'(8'h10 + s));
    send_beat(FUNC_BUILD, 8'h00);
    for (int s = 0; s < 8; s++) send_beat(FUNC_LOOKUP, 8'(8'h10 + s));
    send_beat(FUNC_LOOKUP, 8'hff);
  endtask

  // Hold the receiver off while lookups keep coming, so the input stalls.
  task automatic test_backpressure;
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_beat(FUNC_LOOKUP, 8'(8'h10 + i));
    wait (hold_cycles >= 400);
    hold_req = 1'b0;
  endtask

  // Mostly counts over symbols below span, some lookups and dropped beats, rare builds.
  task automatic test_random_traffic(input int beats, input int span, input int builds);
    int pick;
    int every;
    every = beats / (builds + 1);
    for (int i = 1; i <= beats; i++) begin
      pick = $urandom_range(0, 99);
      if (i % every == 0 && builds > 0) begin
        send_beat(FUNC_BUILD, 8'($urandom));
        builds--;
      end else if (pick < 70) begin
        send_beat(FUNC_COUNT, 8'($urandom_range(0, span - 1)));
      end else if (pick < 95) begin
        send_beat(FUNC_LOOKUP, 8'($urandom));
      end else begin
        send_beat(FUNC_UNUSED, 8'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NSYM; i++) begin
      hist_cnt[i] = 0;
      len_tab[i] = 0;
      code_tab[i] = 0;
    end
    table_ok = 0;
    any_sat = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_lone_symbol();
    test_skewed_tree();
    test_backpressure();
    test_random_traffic(300, 24, 6);
    test_random_traffic(300, 256, 2);
    quiet = 1'b1;
    test_random_traffic(150, 256, 1);
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("huffman_code_table_builder_top test passed");
    end else begin
      $display("huffman_code_table_builder_top test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("huffman_code_table_builder_top test failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/hcb_pkg.sv
hw/rtl/hcb_ram.sv
hw/rtl/hcb_ctrl.sv
hw/rtl/hcb_dp.sv
hw/rtl/huffman_code_table_builder_top.sv
tb/tb_top.sv
